// ===== src/barycentric_hit_attributes_top_defines.svh =====
// assertion macros for the barycentric hit attribute block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BARYCENTRIC_HIT_ATTRIBUTES_TOP_DEFINES_SVH
`define BARYCENTRIC_HIT_ATTRIBUTES_TOP_DEFINES_SVH

// same-cycle implication
`define BHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bha_pkg.sv =====
// package for the barycentric hit attribute block: widths, latencies,
// transfer structs and the component saturation function; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bha_pkg;

  localparam int COMP_W     = 16;
  localparam int NRM_FRAC   = COMP_W - 2;
  localparam int WGT_W      = 17;
  localparam int WGT_FRAC   = 16;
  localparam int ONE_WGT    = 1 << WGT_FRAC;
  localparam int ALPHA_W    = WGT_W + 2;
  localparam int PROD_W     = ALPHA_W + COMP_W;
  localparam int MIX_W      = PROD_W + 2;
  localparam int EDGE_W     = COMP_W + 1;
  localparam int CP_W       = 2 * EDGE_W;
  localparam int CROSS_W    = CP_W + 1;

  // normalization datapath
  localparam int NORM_LO_BIT = 22;
  localparam int NORM_HI_BIT = 24;
  localparam int SCL_W       = NORM_HI_BIT + 2;
  localparam int MAG_W       = NORM_HI_BIT + 1;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SQRT_STEPS  = MAG_W;
  localparam int LEN_W       = MAG_W;
  localparam int QUO_W       = COMP_W;
  localparam int CMP_W       = LEN_W + 1 + QUO_W;
  localparam int NORM_LAT    = 7 + SQRT_STEPS + QUO_W;
  localparam int FRONT_LAT   = 4;
  localparam int TOTAL_LAT   = FRONT_LAT + NORM_LAT;

  typedef logic [3*COMP_W-1:0] vec3_t;
  typedef logic [2*COMP_W-1:0] vec2_t;

  typedef struct packed {
    vec3_t            pos_a;
    vec3_t            pos_b;
    vec3_t            pos_c;
    vec3_t            norm_a;
    vec3_t            norm_b;
    vec3_t            norm_c;
    vec2_t            uv_a;
    vec2_t            uv_b;
    vec2_t            uv_c;
    logic [WGT_W-1:0] weight_beta;
    logic [WGT_W-1:0] weight_gamma;
  } hit_in_t;

  typedef struct packed {
    vec3_t hit_pos;
    vec3_t shade_normal;
    vec3_t geom_normal;
    vec2_t hit_uv;
    logic  degenerate;
  } hit_out_t;

  function automatic logic [COMP_W-1:0] sat_comp(input logic signed [MIX_W-1:0] v);
    logic signed [MIX_W-1:0] hi;
    logic signed [MIX_W-1:0] lo;
    hi = {{(MIX_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[COMP_W-1:0];
    end else if (v < lo) begin
      return lo[COMP_W-1:0];
    end else begin
      return v[COMP_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/barycentric_hit_attributes_top.sv =====
// pipeline: an accepted transfer passes the 4 interpolation stages and then
// the 48-stage normalization pipeline before its result is accepted
// throughput: one hit per cycle, busy stays low, set by the fully pipelined
// square root and divide stages; the receiver cannot stall
// reset: asynchronous active low, clears all valid bits, no result in flight
`timescale 1ns / 1ps
`default_nettype none
`include "barycentric_hit_attributes_top_defines.svh"

module barycentric_hit_attributes_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire bha_pkg::hit_in_t  hit_i,
  output bha_pkg::hit_out_t      res_o,
  output logic                   done_o
);

  localparam int NATTR = 8;
  localparam int CW    = bha_pkg::COMP_W;
  localparam int PW    = bha_pkg::PROD_W;
  localparam int MW    = bha_pkg::MIX_W;
  localparam int EW    = bha_pkg::EDGE_W;
  localparam int CPW   = bha_pkg::CP_W;
  localparam int XW    = bha_pkg::CROSS_W;
  localparam int NL    = bha_pkg::NORM_LAT;
  localparam logic signed [MW-1:0] RndHalf = MW'(1) << (bha_pkg::WGT_FRAC - 1);

  assign busy = 1'b0;

  logic v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: input register
  bha_pkg::hit_in_t hit_q;

  always_ff @(posedge clk_i) begin
    hit_q <= hit_i;
  end

  // stage 2: weight products and edges
  logic signed [CW-1:0] ca [NATTR];
  logic signed [CW-1:0] cb [NATTR];
  logic signed [CW-1:0] cc [NATTR];
  logic signed [bha_pkg::ALPHA_W-1:0] alpha;
  logic signed [PW-1:0] wa_x, wb_x, wc_x;
  logic signed [PW-1:0] pa_q [NATTR];
  logic signed [PW-1:0] pb_q [NATTR];
  logic signed [PW-1:0] pc_q [NATTR];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca[i]   = hit_q.pos_a[i*CW +: CW];
      cb[i]   = hit_q.pos_b[i*CW +: CW];
      cc[i]   = hit_q.pos_c[i*CW +: CW];
      ca[3+i] = hit_q.norm_a[i*CW +: CW];
      cb[3+i] = hit_q.norm_b[i*CW +: CW];
      cc[3+i] = hit_q.norm_c[i*CW +: CW];
    end
    for (int i = 0; i < 2; i++) begin
      ca[6+i] = hit_q.uv_a[i*CW +: CW];
      cb[6+i] = hit_q.uv_b[i*CW +: CW];
      cc[6+i] = hit_q.uv_c[i*CW +: CW];
    end
  end

  assign alpha = bha_pkg::ALPHA_W'(bha_pkg::ONE_WGT)
               - bha_pkg::ALPHA_W'(hit_q.weight_beta)
               - bha_pkg::ALPHA_W'(hit_q.weight_gamma);
  assign wa_x = PW'(alpha);
  assign wb_x = PW'($signed({1'b0, hit_q.weight_beta}));
  assign wc_x = PW'($signed({1'b0, hit_q.weight_gamma}));

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NATTR; j++) begin
      pa_q[j] <= wa_x * PW'(ca[j]);
      pb_q[j] <= wb_x * PW'(cb[j]);
      pc_q[j] <= wc_x * PW'(cc[j]);
    end
    for (int i = 0; i < 3; i++) begin
      e1_q[i] <= EW'(cc[i]) - EW'(ca[i]);
      e2_q[i] <= EW'(cb[i]) - EW'(ca[i]);
    end
  end

  // stage 3: exact sums and cross partial products
  logic signed [MW-1:0]  s_q  [NATTR];
  logic signed [CPW-1:0] cp_q [6];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < NATTR; j++) begin
      s_q[j] <= MW'(pa_q[j]) + MW'(pb_q[j]) + MW'(pc_q[j]);
    end
    cp_q[0] <= CPW'(e1_q[1]) * CPW'(e2_q[2]);
    cp_q[1] <= CPW'(e1_q[2]) * CPW'(e2_q[1]);
    cp_q[2] <= CPW'(e1_q[2]) * CPW'(e2_q[0]);
    cp_q[3] <= CPW'(e1_q[0]) * CPW'(e2_q[2]);
    cp_q[4] <= CPW'(e1_q[0]) * CPW'(e2_q[1]);
    cp_q[5] <= CPW'(e1_q[1]) * CPW'(e2_q[0]);
  end

  // stage 4: round and saturate, cross difference
  bha_pkg::vec3_t   pos_d, pos_q;
  bha_pkg::vec2_t   uv_d, uv_q;
  logic [3*MW-1:0]  nv_q;
  logic [3*XW-1:0]  cr_q;

  always_comb begin
    logic signed [MW-1:0] t;
    pos_d = '0;
    uv_d  = '0;
    for (int i = 0; i < 3; i++) begin
      t = s_q[i] + RndHalf;
      pos_d[i*CW +: CW] = bha_pkg::sat_comp(t >>> bha_pkg::WGT_FRAC);
    end
    for (int i = 0; i < 2; i++) begin
      t = s_q[6+i] + RndHalf;
      uv_d[i*CW +: CW] = bha_pkg::sat_comp(t >>> bha_pkg::WGT_FRAC);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    uv_q  <= uv_d;
    nv_q  <= {s_q[5], s_q[4], s_q[3]};
    cr_q  <= {XW'(cp_q[4]) - XW'(cp_q[5]),
              XW'(cp_q[2]) - XW'(cp_q[3]),
              XW'(cp_q[0]) - XW'(cp_q[1])};
  end

  // normalization
  logic           sn_vld, gn_vld, sn_zero, gn_zero;
  bha_pkg::vec3_t sn_nrm, gn_nrm;

  bha_norm #(.IN_W(MW)) u_shade_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .vec_i   (nv_q),
    .valid_o (sn_vld),
    .nrm_o   (sn_nrm),
    .zero_o  (sn_zero)
  );

  bha_norm #(.IN_W(XW)) u_geom_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .vec_i   (cr_q),
    .valid_o (gn_vld),
    .nrm_o   (gn_nrm),
    .zero_o  (gn_zero)
  );

  // align position and uv with the normalization latency
  bha_pkg::vec3_t dpos_q [NL];
  bha_pkg::vec2_t duv_q  [NL];

  always_ff @(posedge clk_i) begin
    dpos_q[0] <= pos_q;
    duv_q[0]  <= uv_q;
    for (int i = 1; i < NL; i++) begin
      dpos_q[i] <= dpos_q[i-1];
      duv_q[i]  <= duv_q[i-1];
    end
  end

  assign done_o             = sn_vld && gn_vld;
  assign res_o.hit_pos      = dpos_q[NL-1];
  assign res_o.shade_normal = sn_nrm;
  assign res_o.geom_normal  = gn_nrm;
  assign res_o.hit_uv       = duv_q[NL-1];
  assign res_o.degenerate   = sn_zero || gn_zero;

  `BHA_ASSERT_IMP(a_done_src, done_o, $past(start, bha_pkg::TOTAL_LAT), "result without transfer")
  `BHA_ASSERT_IMP(a_degen_zero, done_o && res_o.degenerate, (res_o.shade_normal == '0 || res_o.geom_normal == '0), "degenerate flag without zero normal")
  `BHA_ASSERT_IMP(a_nondegen_nz, done_o && !res_o.degenerate, (res_o.shade_normal != '0 && res_o.geom_normal != '0), "zero normal without degenerate flag")

endmodule

`default_nettype wire

// ===== src/bha_norm.sv =====
// vector normalization pipeline: scale, sum of squares, digit-serial
// square root stages, restoring divide stages; uses bha_pkg
`timescale 1ns / 1ps
`default_nettype none

module bha_norm #(
  parameter int IN_W = bha_pkg::MIX_W
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic [3*IN_W-1:0]    vec_i,
  output logic                      valid_o,
  output bha_pkg::vec3_t            nrm_o,
  output logic                      zero_o
);

  localparam int PW    = $clog2(IN_W);
  localparam int EXT_W = IN_W + bha_pkg::NORM_HI_BIT;
  localparam int SQS   = bha_pkg::SQRT_STEPS;
  localparam int QW    = bha_pkg::QUO_W;
  localparam int SCW   = bha_pkg::SCL_W;
  localparam int CW    = bha_pkg::CMP_W;

  logic [bha_pkg::NORM_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[bha_pkg::NORM_LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[bha_pkg::NORM_LAT-1];

  // stage 1: magnitudes and maximum
  logic signed [IN_W-1:0] w1_q [3];
  logic [IN_W-1:0]        mx1_d, mx1_q;
  logic                   z1_q;

  always_comb begin
    logic [IN_W-1:0] ab [3];
    for (int i = 0; i < 3; i++) begin
      ab[i] = vec_i[i*IN_W + IN_W-1] ? IN_W'(-$signed(vec_i[i*IN_W +: IN_W]))
                                     : vec_i[i*IN_W +: IN_W];
    end
    mx1_d = ab[0];
    if (ab[1] > mx1_d) begin
      mx1_d = ab[1];
    end
    if (ab[2] > mx1_d) begin
      mx1_d = ab[2];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      w1_q[i] <= $signed(vec_i[i*IN_W +: IN_W]);
    end
    mx1_q <= mx1_d;
    z1_q  <= (mx1_d == '0);
  end

  // stage 2: leading one and shift amount
  logic signed [IN_W-1:0] w2_q [3];
  logic                   rsh2_d, rsh2_q;
  logic [PW-1:0]          amt2_d, amt2_q;
  logic                   z2_q;

  always_comb begin
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (mx1_q[i]) begin
        p = PW'(i);
      end
    end
    rsh2_d = (p > PW'(bha_pkg::NORM_HI_BIT - 1));
    if (rsh2_d) begin
      amt2_d = p - PW'(bha_pkg::NORM_HI_BIT - 1);
    end else if (p < PW'(bha_pkg::NORM_LO_BIT)) begin
      amt2_d = PW'(bha_pkg::NORM_LO_BIT) - p;
    end else begin
      amt2_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    w2_q   <= w1_q;
    rsh2_q <= rsh2_d;
    amt2_q <= amt2_d;
    z2_q   <= z1_q;
  end

  // stage 3: scale into range
  logic signed [SCW-1:0] w3_d [3];
  logic signed [SCW-1:0] w3_q [3];
  logic                  z3_q;

  always_comb begin
    logic signed [EXT_W-1:0] ext;
    logic signed [EXT_W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      ext = EXT_W'(w2_q[i]);
      sh  = rsh2_q ? (ext >>> amt2_q) : (ext <<< amt2_q);
      w3_d[i] = sh[SCW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    w3_q <= w3_d;
    z3_q <= z2_q;
  end

  // stage 4: squares
  logic [bha_pkg::SQ_W-1:0] sq4_d [3];
  logic [bha_pkg::SQ_W-1:0] sq4_q [3];
  logic signed [SCW-1:0]    w4_q [3];
  logic                     z4_q;

  always_comb begin
    logic [bha_pkg::MAG_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      m = w3_q[i][SCW-1] ? bha_pkg::MAG_W'(-w3_q[i]) : bha_pkg::MAG_W'(w3_q[i]);
      sq4_d[i] = bha_pkg::SQ_W'(m) * bha_pkg::SQ_W'(m);
    end
  end

  always_ff @(posedge clk_i) begin
    sq4_q <= sq4_d;
    w4_q  <= w3_q;
    z4_q  <= z3_q;
  end

  // stage 5 and square root stages
  logic [bha_pkg::SQ_W-1:0] rem_q [SQS+1];
  logic [bha_pkg::SQ_W-1:0] res_q [SQS+1];
  logic signed [SCW-1:0]    sw_q  [SQS+1][3];
  logic [SQS:0]             sz_q;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= sq4_q[0] + sq4_q[1] + sq4_q[2];
    res_q[0] <= '0;
    sw_q[0]  <= w4_q;
    sz_q[0]  <= z4_q;
  end

  for (genvar k = 0; k < SQS; k++) begin : g_sqrt
    localparam logic [bha_pkg::SQ_W-1:0] BitV = bha_pkg::SQ_W'(1) << (bha_pkg::SQ_W - 2 - 2*k);
    logic [bha_pkg::SQ_W-1:0] rem_d, res_d, t_d;

    always_comb begin
      t_d = res_q[k] + BitV;
      if (rem_q[k] >= t_d) begin
        rem_d = rem_q[k] - t_d;
        res_d = (res_q[k] >> 1) + BitV;
      end else begin
        rem_d = rem_q[k];
        res_d = res_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      res_q[k+1] <= res_d;
      sw_q[k+1]  <= sw_q[k];
      sz_q[k+1]  <= sz_q[k];
    end
  end

  // divide setup
  logic [CW-1:0]                  num_q [QW+1][3];
  logic [QW-1:0]                  quo_q [QW+1][3];
  logic [bha_pkg::LEN_W:0]        den_q [QW+1];
  logic [2:0]                     sgn_q [QW+1];
  logic [QW:0]                    dz_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      num_q[0][i] <= (CW'(sw_q[SQS][i][SCW-1] ? bha_pkg::MAG_W'(-sw_q[SQS][i])
                                              : bha_pkg::MAG_W'(sw_q[SQS][i]))
                      << (bha_pkg::NRM_FRAC + 1))
                     + CW'(res_q[SQS][bha_pkg::LEN_W-1:0]);
      quo_q[0][i] <= '0;
      sgn_q[0][i] <= sw_q[SQS][i][SCW-1];
    end
    den_q[0] <= {res_q[SQS][bha_pkg::LEN_W-1:0], 1'b0};
    dz_q[0]  <= sz_q[SQS];
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [CW-1:0] dsh_d;
    logic [CW-1:0] num_d [3];
    logic [QW-1:0] quo_d [3];

    always_comb begin
      dsh_d = CW'(den_q[k]) << B;
      for (int i = 0; i < 3; i++) begin
        num_d[i] = num_q[k][i];
        quo_d[i] = quo_q[k][i];
        if (num_q[k][i] >= dsh_d) begin
          num_d[i]    = num_q[k][i] - dsh_d;
          quo_d[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k+1] <= num_d;
      quo_q[k+1] <= quo_d;
      den_q[k+1] <= den_q[k];
      sgn_q[k+1] <= sgn_q[k];
      dz_q[k+1]  <= dz_q[k];
    end
  end

  // sign, saturate, pack
  bha_pkg::vec3_t nrm_d, nrm_q;
  logic           zero_q;

  always_comb begin
    logic signed [bha_pkg::MIX_W-1:0] qx;
    nrm_d = '0;
    for (int i = 0; i < 3; i++) begin
      qx = bha_pkg::MIX_W'(quo_q[QW][i]);
      if (sgn_q[QW][i]) begin
        qx = -qx;
      end
      nrm_d[i*bha_pkg::COMP_W +: bha_pkg::COMP_W] = bha_pkg::sat_comp(qx);
    end
    if (dz_q[QW]) begin
      nrm_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    nrm_q  <= nrm_d;
    zero_q <= dz_q[QW];
  end

  assign nrm_o  = nrm_q;
  assign zero_o = zero_q;

endmodule

`default_nettype wire

// ===== sim/tb_barycentric_hit_attributes_top.sv =====
// self-checking testbench for barycentric_hit_attributes_top: directed and random hits,
// each result checked against an in-bench fixed-point interpolation and normalization model
// depends on bha_pkg and the barycentric_hit_attributes_top rtl
`timescale 1ns / 1ps

module tb_barycentric_hit_attributes_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = bha_pkg::TOTAL_LAT + 20;
  localparam int CW             = bha_pkg::COMP_W;
  localparam int WW             = bha_pkg::WGT_W;

  typedef longint trio_t[3];

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start;
  logic              busy;
  bha_pkg::hit_in_t  hit_i;
  bha_pkg::hit_out_t res_o;
  logic              done_o;

  bha_pkg::hit_in_t  pending_hits[$];
  bha_pkg::hit_out_t expected_attrs[$];
  int       burst_left = 0;
  int       gap_left = 0;
  int       idle_cycles = 0;
  bit       failed = 1'b0;

  always #6 clk_i = ~clk_i;

  barycentric_hit_attributes_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .hit_i  (hit_i),
    .res_o  (res_o),
    .done_o (done_o)
  );

  function automatic longint comp(input bha_pkg::vec3_t w, input int i);
    logic signed [CW-1:0] t;
    t = w[i*CW +: CW];
    return longint'(t);
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint round_mix(input longint s);
    return clamp16((s + 32768) >>> 16);
  endfunction

  function automatic longint int_sqrt(input longint n);
    longint res;
    longint b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bha_pkg::vec3_t unit_vector(input trio_t v, output logic is_zero);
    trio_t w;
    longint mx, len2, len, n, q;
    bha_pkg::vec3_t packed_out;
    mx = 0;
    packed_out = '0;
    for (int i = 0; i < 3; i++) begin
      w[i] = v[i];
      if ((v[i] < 0 ? -v[i] : v[i]) > mx) mx = (v[i] < 0 ? -v[i] : v[i]);
    end
    if (mx == 0) begin
      is_zero = 1'b1;
      return '0;
    end
    while (mx >= (longint'(1) << bha_pkg::NORM_HI_BIT)) begin
      for (int i = 0; i < 3; i++) w[i] = w[i] >>> 1;
      mx = mx >>> 1;
    end
    while (mx < (longint'(1) << bha_pkg::NORM_LO_BIT)) begin
      for (int i = 0; i < 3; i++) w[i] = w[i] * 2;
      mx = mx * 2;
    end
    len2 = 0;
    for (int i = 0; i < 3; i++) len2 += w[i] * w[i];
    len = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      n = (w[i] < 0 ? -w[i] : w[i]) << bha_pkg::NRM_FRAC;
      q = (2 * n + len) / (2 * len);
      if (w[i] < 0) q = -q;
      packed_out[i*CW +: CW] = CW'(clamp16(q));
    end
    is_zero = 1'b0;
    return packed_out;
  endfunction

  function automatic bha_pkg::hit_out_t predict_attrs(input bha_pkg::hit_in_t h);
    bha_pkg::hit_out_t r;
    longint wb, wc, wa;
    trio_t nv, e1, e2, cr;
    logic z_shade, z_geom;
    wb = longint'(h.weight_beta);
    wc = longint'(h.weight_gamma);
    wa = bha_pkg::ONE_WGT - wb - wc;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      r.hit_pos[i*CW +: CW] = CW'(round_mix(wa * comp(h.pos_a, i) +
          wb * comp(h.pos_b, i) + wc * comp(h.pos_c, i)));
      nv[i] = wa * comp(h.norm_a, i) + wb * comp(h.norm_b, i) + wc * comp(h.norm_c, i);
      e1[i] = comp(h.pos_c, i) - comp(h.pos_a, i);
      e2[i] = comp(h.pos_b, i) - comp(h.pos_a, i);
    end
    for (int i = 0; i < 2; i++) begin
      r.hit_uv[i*CW +: CW] = CW'(round_mix(wa * comp({{CW{1'b0}}, h.uv_a}, i) +
          wb * comp({{CW{1'b0}}, h.uv_b}, i) + wc * comp({{CW{1'b0}}, h.uv_c}, i)));
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    r.shade_normal = unit_vector(nv, z_shade);
    r.geom_normal  = unit_vector(cr, z_geom);
    r.degenerate   = z_shade | z_geom;
    return r;
  endfunction

  function automatic bha_pkg::vec3_t rand_normal();
    bha_pkg::vec3_t v;
    for (int i = 0; i < 3; i++)
      v[i*CW +: CW] = CW'($signed($urandom_range(0, 32768)) - 16384);
    return v;
  endfunction

  // mostly well-formed hits, some full-range noise
  function automatic bha_pkg::hit_in_t random_hit();
    bha_pkg::hit_in_t h;
    logic [447:0]     rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    h = rnd[$bits(bha_pkg::hit_in_t)-1:0];
    case ($urandom_range(0, 9))
      0, 1: ;
      2: begin
        h.pos_b = h.pos_a;
        h.norm_a = '0; h.norm_b = '0; h.norm_c = '0;
      end
      default: begin
        h.norm_a = rand_normal();
        h.norm_b = rand_normal();
        h.norm_c = rand_normal();
        h.weight_beta  = WW'($urandom_range(0, bha_pkg::ONE_WGT));
        h.weight_gamma = WW'($urandom_range(0, bha_pkg::ONE_WGT - h.weight_beta));
      end
    endcase
    return h;
  endfunction

  task automatic load_directed();
    bha_pkg::hit_in_t h;
    h = '0;
    pending_hits.push_back(h);
    h.pos_b = {16'sd0, 16'sd0, 16'sd256};
    h.pos_c = {16'sd0, 16'sd256, 16'sd0};
    h.norm_a = {16'sd16384, 16'sd0, 16'sd0};
    h.norm_b = h.norm_a; h.norm_c = h.norm_a;
    for (int k = 0; k < 4; k++) begin
      h.weight_beta  = (k == 1) ? WW'(bha_pkg::ONE_WGT) : (k == 3 ? 17'h1FFFF : 17'd0);
      h.weight_gamma = (k == 2) ? WW'(bha_pkg::ONE_WGT) : (k == 3 ? 17'h1FFFF : 17'd0);
      pending_hits.push_back(h);
    end
    // all extremes of positions, normals and uvs
    h = {{6{48'h7FFF7FFF7FFF}}, {3{32'h7FFF7FFF}}, 17'd0, 17'd0};
    pending_hits.push_back(h);
    h = {{6{48'h800080008000}}, {3{32'h80008000}}, 17'd32768, 17'd32768};
    pending_hits.push_back(h);
    h = {48'h800080008000, 48'h7FFF7FFF7FFF, 48'h800000007FFF,
         48'h800080008000, 48'h7FFF7FFF7FFF, 48'h0,
         32'h80008000, 32'h7FFF7FFF, 32'h00007FFF, 17'h1FFFF, 17'd65536};
    pending_hits.push_back(h);
    // opposite normals cancel to zero length
    h = '0;
    h.pos_b = {16'sd0, 16'sd0, 16'sd100};
    h.pos_c = {16'sd0, 16'sd100, 16'sd0};
    h.norm_a = {16'sd0, 16'sd16384, 16'sd0};
    h.norm_b = {16'sd0, -16'sd16384, 16'sd0};
    h.weight_beta = 17'd32768;
    pending_hits.push_back(h);
    // collinear triangle
    h.pos_c = {16'sd0, 16'sd0, 16'sd200};
    h.norm_b = h.norm_a;
    pending_hits.push_back(h);
    // rounding at half steps
    h = '0;
    h.pos_b = {16'sd1, -16'sd1, 16'sd1};
    h.pos_c = {16'sd5, 16'sd3, -16'sd3};
    h.uv_b = {16'sd1, -16'sd1};
    h.norm_a = {16'sd1, 16'sd0, 16'sd0};
    h.weight_beta = 17'd32768;
    pending_hits.push_back(h);
    for (int k = 0; k < 8; k++) pending_hits.push_back(random_hit());
  endtask

  // sender: bursts and gaps; busy is honored though it stays low
  always @(posedge clk_i) begin
    logic              nxt_start;
    bha_pkg::hit_in_t  nxt_hit;
    nxt_start = start;
    nxt_hit   = hit_i;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_attrs.push_back(predict_attrs(hit_i));
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_hits.size() > 0) begin
          nxt_hit   = pending_hits.pop_front();
          nxt_start = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    start <= nxt_start;
    hit_i <= nxt_hit;
  end

  // result check
  always @(posedge clk_i) begin
    bha_pkg::hit_out_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_attrs.size() == 0) begin
        $error("unexpected result transfer: %h", res_o);
        failed = 1'b1;
      end else begin
        exp_r = expected_attrs.pop_front();
        if (res_o.hit_pos !== exp_r.hit_pos) begin
          $error("hit_pos exp %h act %h", exp_r.hit_pos, res_o.hit_pos);
          failed = 1'b1;
        end
        if (res_o.shade_normal !== exp_r.shade_normal) begin
          $error("shade_normal exp %h act %h", exp_r.shade_normal, res_o.shade_normal);
          failed = 1'b1;
        end
        if (res_o.geom_normal !== exp_r.geom_normal) begin
          $error("geom_normal exp %h act %h", exp_r.geom_normal, res_o.geom_normal);
          failed = 1'b1;
        end
        if (res_o.hit_uv !== exp_r.hit_uv) begin
          $error("hit_uv exp %h act %h", exp_r.hit_uv, res_o.hit_uv);
          failed = 1'b1;
        end
        if (res_o.degenerate !== exp_r.degenerate) begin
          $error("degenerate exp %b act %b", exp_r.degenerate, res_o.degenerate);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no transfer either way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    start <= 1'b0;
    hit_i <= '0;
    load_directed();
    for (int k = 0; k < 2000; k++) pending_hits.push_back(random_hit());
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_hits.size() == 0);
    @(posedge clk_i iff !start);
    wait (expected_attrs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed && expected_attrs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
